// File: rtl/ezp_pkg.sv
// Package for the ZYX Euler pose to transform unit.
// Holds CORDIC constants, the arctangent table and rounding helpers.
// No dependencies.
`timescale 1ns / 1ps
package ezp_pkg;

  localparam int unsigned CordicStepsDef = 14;
  localparam int unsigned TblLen = 24;
  localparam int unsigned PosW = 24;
  localparam int unsigned AngW = 16;
  localparam int unsigned RotW = 16;
  localparam int unsigned CordW = 34;
  localparam int unsigned QueueDepth = 4;

  localparam logic signed [CordW-1:0] Q30Pi = 34'sd3373259426;
  localparam logic signed [CordW-1:0] Q30HalfPi = 34'sd1686629713;
  localparam logic signed [CordW-1:0] Q30GainInv = 34'sh026DD3B6A;
  localparam logic signed [RotW-1:0] OneQ14 = 16'sd16384;

  typedef struct packed {
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic signed [PosW-1:0] pz;
    logic signed [AngW-1:0] ar;
    logic signed [AngW-1:0] ap;
    logic signed [AngW-1:0] ay;
  } pose_t;

  typedef struct packed {
    logic signed [RotW-1:0] c;
    logic signed [RotW-1:0] s;
  } sc_t;

  typedef struct packed {
    logic signed [RotW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [PosW-1:0] px, py, pz;
  } xform_t;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'sh03243F6A8;
      5'd1: atan_q30 = 34'sh01DAC6705;
      5'd2: atan_q30 = 34'sh00FADBAFC;
      5'd3: atan_q30 = 34'sh007F56EA6;
      5'd4: atan_q30 = 34'sh003FEAB76;
      5'd5: atan_q30 = 34'sh001FFD55B;
      5'd6: atan_q30 = 34'sh000FFFAAA;
      5'd7: atan_q30 = 34'sh0007FFF55;
      5'd8: atan_q30 = 34'sh0003FFFEA;
      5'd9: atan_q30 = 34'sh0001FFFFD;
      5'd10: atan_q30 = 34'sh0000FFFFF;
      5'd11: atan_q30 = 34'sh00007FFFF;
      5'd12: atan_q30 = 34'sh00003FFFF;
      5'd13: atan_q30 = 34'sh00001FFFF;
      5'd14: atan_q30 = 34'sh00000FFFF;
      5'd15: atan_q30 = 34'sh000007FFF;
      5'd16: atan_q30 = 34'sh000003FFF;
      5'd17: atan_q30 = 34'sh000001FFF;
      5'd18: atan_q30 = 34'sh000000FFF;
      5'd19: atan_q30 = 34'sh0000007FF;
      5'd20: atan_q30 = 34'sh0000003FF;
      5'd21: atan_q30 = 34'sh0000001FF;
      5'd22: atan_q30 = 34'sh0000000FF;
      5'd23: atan_q30 = 34'sh00000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

  // Round a Q30 CORDIC value to Q14 and clamp to plus or minus one.
  function automatic logic signed [RotW-1:0] rnd_q30(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] r;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) rnd_q30 = OneQ14;
    else if (r < -34'sd16384) rnd_q30 = -OneQ14;
    else rnd_q30 = r[RotW-1:0];
  endfunction

  // Round a Q28 product to Q14 and clamp.
  function automatic logic signed [RotW-1:0] rnd_q28(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = (v + 33'sd8192) >>> 14;
    if (r > 33'sd16384) rnd_q28 = OneQ14;
    else if (r < -33'sd16384) rnd_q28 = -OneQ14;
    else rnd_q28 = r[RotW-1:0];
  endfunction

  // Round a Q42 sum to Q14 and clamp.
  function automatic logic signed [RotW-1:0] rnd_q42(input logic signed [47:0] v);
    logic signed [47:0] r;
    r = (v + (48'sd1 <<< 27)) >>> 28;
    if (r > 48'sd16384) rnd_q42 = OneQ14;
    else if (r < -48'sd16384) rnd_q42 = -OneQ14;
    else rnd_q42 = r[RotW-1:0];
  endfunction

endpackage

// File: rtl/ezp_cordic.sv
// Pipelined rotation-mode CORDIC giving Q14 cosine and sine of a Q2.13 angle.
// One stage per iteration; advances when en_i is high. Uses ezp_pkg.
`timescale 1ns / 1ps
module ezp_cordic #(
  parameter int unsigned Steps = ezp_pkg::CordicStepsDef
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [ezp_pkg::AngW-1:0]  ang_i,
  output ezp_pkg::sc_t                     sc_o
);
  import ezp_pkg::*;

  localparam int unsigned N = (Steps < TblLen) ? Steps : TblLen;

  logic signed [CordW-1:0] x_q [N+1];
  logic signed [CordW-1:0] y_q [N+1];
  logic signed [CordW-1:0] z_q [N+1];
  logic                    f_q [N+1];

  logic signed [CordW-1:0] z0;
  assign z0 = {{(CordW-AngW-17){ang_i[AngW-1]}}, ang_i, 17'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= Q30GainInv;
      y_q[0] <= '0;
      if (z0 > Q30HalfPi) begin
        z_q[0] <= z0 - Q30Pi;
        f_q[0] <= 1'b1;
      end else if (z0 < -Q30HalfPi) begin
        z_q[0] <= z0 + Q30Pi;
        f_q[0] <= 1'b1;
      end else begin
        z_q[0] <= z0;
        f_q[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[i+1] <= f_q[i];
        if (!z_q[i][CordW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_q30(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_q30(5'(i));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_o.c <= rnd_q30(f_q[N] ? -x_q[N] : x_q[N]);
      sc_o.s <= rnd_q30(f_q[N] ? -y_q[N] : y_q[N]);
    end
  end
endmodule

// File: rtl/ezp_front.sv
// Front end: accepts poses and runs three CORDICs, then pushes sines and
// cosines with the translation into the mid queue. Uses ezp_pkg, ezp_cordic.
`timescale 1ns / 1ps
module ezp_front #(
  parameter int unsigned Steps = ezp_pkg::CordicStepsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  ezp_pkg::pose_t  pose_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output ezp_pkg::pose_t  q_pose_o,
  output ezp_pkg::sc_t    q_r_o,
  output ezp_pkg::sc_t    q_p_o,
  output ezp_pkg::sc_t    q_y_o
);
  import ezp_pkg::*;

  // Pose bits at stage 0, then one stage per iteration, then the rounding stage.
  localparam int unsigned Lat = ((Steps < TblLen) ? Steps : TblLen) + 2;

  logic           en;
  logic [Lat-1:0] v_q;
  pose_t          p_q [Lat];

  // The whole pipe stalls only when its last stage holds an item the queue
  // cannot take.
  assign en = !(v_q[Lat-1] && q_full_i);
  assign full_o = !en;
  assign q_push_o = v_q[Lat-1] && !q_full_i;
  assign q_pose_o = p_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Lat-2:0], push_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= pose_i;
      for (int i = 1; i < Lat; i++) p_q[i] <= p_q[i-1];
    end
  end

  ezp_cordic #(.Steps(Steps)) u_r (.clk_i, .en_i(en), .ang_i(pose_i.ar), .sc_o(q_r_o));
  ezp_cordic #(.Steps(Steps)) u_p (.clk_i, .en_i(en), .ang_i(pose_i.ap), .sc_o(q_p_o));
  ezp_cordic #(.Steps(Steps)) u_y (.clk_i, .en_i(en), .ang_i(pose_i.ay), .sc_o(q_y_o));
endmodule

// File: rtl/ezp_queue.sv
// Small register FIFO, used between the front and back ends and as the result queue.
// Generic over a packed payload width. Uses ezp_pkg for its depth.
`timescale 1ns / 1ps
module ezp_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);
  import ezp_pkg::*;

  localparam int unsigned Aw = $clog2(QueueDepth);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [Aw-1:0]    wp_q, rp_q;
  logic [Aw:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (Aw+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end
endmodule

// File: rtl/ezp_back.sv
// Back end: forms the nine rotation entries from sines and cosines in a
// three-stage multiply pipeline behind an output FIFO. Uses ezp_pkg, ezp_queue.
`timescale 1ns / 1ps
module ezp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_empty_i,
  output logic            in_pop_o,
  input  ezp_pkg::pose_t  pose_i,
  input  ezp_pkg::sc_t    r_i,
  input  ezp_pkg::sc_t    p_i,
  input  ezp_pkg::sc_t    y_i,
  input  logic            pop_i,
  output logic            empty_o,
  output ezp_pkg::xform_t res_o
);
  import ezp_pkg::*;

  localparam int unsigned Lat = 3;

  // Credit count keeps in-flight items within the output FIFO's free space.
  logic [$clog2(QueueDepth+1)-1:0] used_q;
  logic [Lat-1:0] v_q;
  logic           take, out_pop, of_full;

  // Stage 1: two-term products.
  pose_t p1_q;
  logic signed [31:0] a_q, b_q, ycp_q, ysp_q, rcp_q, rcr_q, scr_q, ssr_q, csr_q, ccr_q;
  logic signed [RotW-1:0] sp1_q, sr1_q, cr1_q;
  // Stage 2: two-term sums in Q42; the plain products pass on in Q28.
  pose_t p2_q;
  logic signed [47:0] s01_q, s02_q, s11_q, s12_q;
  logic signed [31:0] m00_q, m10_q, m21_q, m22_q;
  logic signed [RotW-1:0] sp2_q;
  // Stage 3: rounded result.
  xform_t x3_q;

  assign out_pop = pop_i && !empty_o;
  // A result leaving this cycle frees a credit for a new request at once.
  assign take = !in_empty_i &&
                ((used_q < ($bits(used_q))'(QueueDepth)) || out_pop);
  assign in_pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      v_q <= '0;
    end else begin
      used_q <= used_q + ($bits(used_q))'(take) - ($bits(used_q))'(out_pop);
      v_q <= {v_q[Lat-2:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q  <= pose_i;
    a_q   <= 32'(y_i.c * p_i.s);
    b_q   <= 32'(y_i.s * p_i.s);
    ycp_q <= 32'(y_i.c * p_i.c);
    ysp_q <= 32'(y_i.s * p_i.c);
    rcp_q <= 32'(p_i.c * r_i.s);
    rcr_q <= 32'(p_i.c * r_i.c);
    scr_q <= 32'(y_i.s * r_i.c);
    ssr_q <= 32'(y_i.s * r_i.s);
    csr_q <= 32'(y_i.c * r_i.s);
    ccr_q <= 32'(y_i.c * r_i.c);
    sp1_q <= p_i.s;
    sr1_q <= r_i.s;
    cr1_q <= r_i.c;

    p2_q  <= p1_q;
    s01_q <= 48'(a_q * sr1_q) - (48'(scr_q) <<< 14);
    s02_q <= 48'(a_q * cr1_q) + (48'(ssr_q) <<< 14);
    s11_q <= 48'(b_q * sr1_q) + (48'(ccr_q) <<< 14);
    s12_q <= 48'(b_q * cr1_q) - (48'(csr_q) <<< 14);
    m00_q <= ycp_q;
    m10_q <= ysp_q;
    m21_q <= rcp_q;
    m22_q <= rcr_q;
    sp2_q <= sp1_q;

    x3_q.r00 <= rnd_q28(33'(m00_q));
    x3_q.r01 <= rnd_q42(s01_q);
    x3_q.r02 <= rnd_q42(s02_q);
    x3_q.r10 <= rnd_q28(33'(m10_q));
    x3_q.r11 <= rnd_q42(s11_q);
    x3_q.r12 <= rnd_q42(s12_q);
    x3_q.r20 <= -sp2_q;
    x3_q.r21 <= rnd_q28(33'(m21_q));
    x3_q.r22 <= rnd_q28(33'(m22_q));
    x3_q.px  <= p2_q.px;
    x3_q.py  <= p2_q.py;
    x3_q.pz  <= p2_q.pz;
  end

  logic [$bits(xform_t)-1:0] of_data;
  assign res_o = xform_t'(of_data);

  ezp_queue #(.Width($bits(xform_t))) u_out (
    .clk_i, .rst_ni,
    .push_i(v_q[Lat-1]), .data_i(x3_q), .full_o(of_full),
    .pop_i(out_pop), .empty_o, .data_o(of_data)
  );

  // Credits guarantee the FIFO never overflows, so its full flag goes unused
  // beyond this guard.
  logic unused_full;
  assign unused_full = of_full;
endmodule

// File: rtl/euler_zyx_pose_to_transform_unit.sv
// ZYX Euler pose to homogeneous transform, top level.
// Channels: the input (push/full) takes a pose of translation and
// roll, pitch, yaw in Q2.13 radians. The result queue (empty/pop)
// holds R = Rz(yaw)*Ry(pitch)*Rx(roll) in Q1.14 plus the translation.
// Throughput: one pose per cycle, sustained, while the receiver keeps popping,
// set by the fully pipelined CORDICs (one stage per iteration) and the
// three-stage multiply pipe. A pose passes the front pipeline, is written
// into the mid queue, then runs through the back end's multiply stages
// and is written into the output queue before its result shows (CORDIC
// steps capped at 24).
// A four-entry queue between front and back, and a four-entry result queue,
// let each side stall on its own. When the receiver stops popping, the back
// end stops after four results in flight, the mid queue fills, and then
// the front pipeline holds and raises full.
// Reset clears all valid state; both queues come up empty.
// Uses ezp_pkg, ezp_front, ezp_queue, ezp_back.
`timescale 1ns / 1ps
module euler_zyx_pose_to_transform_unit #(
  parameter int unsigned CORDIC_STEPS = ezp_pkg::CordicStepsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  logic signed [ezp_pkg::PosW-1:0] pos_x_i,
  input  logic signed [ezp_pkg::PosW-1:0] pos_y_i,
  input  logic signed [ezp_pkg::PosW-1:0] pos_z_i,
  input  logic signed [ezp_pkg::AngW-1:0] roll_angle_i,
  input  logic signed [ezp_pkg::AngW-1:0] pitch_angle_i,
  input  logic signed [ezp_pkg::AngW-1:0] yaw_angle_i,
  input  logic pop,
  output logic empty,
  output logic signed [ezp_pkg::RotW-1:0] rot_00_o,
  output logic signed [ezp_pkg::RotW-1:0] rot_01_o,
  output logic signed [ezp_pkg::RotW-1:0] rot_02_o,
  output logic signed [ezp_pkg::RotW-1:0] rot_10_o,
  output logic signed [ezp_pkg::RotW-1:0] rot_11_o,
  output logic signed [ezp_pkg::RotW-1:0] rot_12_o,
  output logic signed [ezp_pkg::RotW-1:0] rot_20_o,
  output logic signed [ezp_pkg::RotW-1:0] rot_21_o,
  output logic signed [ezp_pkg::RotW-1:0] rot_22_o,
  output logic signed [ezp_pkg::PosW-1:0] out_x_o,
  output logic signed [ezp_pkg::PosW-1:0] out_y_o,
  output logic signed [ezp_pkg::PosW-1:0] out_z_o
);
  import ezp_pkg::*;

  typedef struct packed {
    pose_t pose;
    sc_t   r;
    sc_t   p;
    sc_t   y;
  } mid_t;

  pose_t  pose_in;
  mid_t   mid_in, mid_out;
  logic   m_push, m_full, m_pop, m_empty;
  xform_t res;
  logic [$bits(mid_t)-1:0] mid_raw;

  assign pose_in = '{px: pos_x_i, py: pos_y_i, pz: pos_z_i,
                     ar: roll_angle_i, ap: pitch_angle_i, ay: yaw_angle_i};

  ezp_front #(.Steps(CORDIC_STEPS)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .pose_i(pose_in),
    .q_full_i(m_full), .q_push_o(m_push), .q_pose_o(mid_in.pose),
    .q_r_o(mid_in.r), .q_p_o(mid_in.p), .q_y_o(mid_in.y)
  );

  ezp_queue #(.Width($bits(mid_t))) u_mid (
    .clk_i, .rst_ni, .push_i(m_push), .data_i(mid_in), .full_o(m_full),
    .pop_i(m_pop), .empty_o(m_empty), .data_o(mid_raw)
  );
  assign mid_out = mid_t'(mid_raw);

  ezp_back u_back (
    .clk_i, .rst_ni, .in_empty_i(m_empty), .in_pop_o(m_pop),
    .pose_i(mid_out.pose), .r_i(mid_out.r), .p_i(mid_out.p), .y_i(mid_out.y),
    .pop_i(pop), .empty_o(empty), .res_o(res)
  );

  assign rot_00_o = res.r00;
  assign rot_01_o = res.r01;
  assign rot_02_o = res.r02;
  assign rot_10_o = res.r10;
  assign rot_11_o = res.r11;
  assign rot_12_o = res.r12;
  assign rot_20_o = res.r20;
  assign rot_21_o = res.r21;
  assign rot_22_o = res.r22;
  assign out_x_o  = res.px;
  assign out_y_o  = res.py;
  assign out_z_o  = res.pz;
endmodule
